/* hdl/fsmc_pkg.sv */
// Shared types, opcodes and status codes of the Forth stack machine core.
`timescale 1ns / 1ps
package fsmc_pkg;

  localparam int WORD_BITS_DEF    = 32;
  localparam int DATA_DEPTH_DEF   = 32;
  localparam int RETURN_DEPTH_DEF = 32;
  localparam int MEM_WORDS_DEF    = 1024;
  localparam int PC_BITS_DEF      = 16;
  localparam int SKIP_WORDS       = 6;

  localparam logic [4:0] CMD_NONE    = 5'd0;
  localparam logic [4:0] CMD_PUSH    = 5'd1;
  localparam logic [4:0] CMD_RET     = 5'd2;
  localparam logic [4:0] CMD_CALL    = 5'd3;
  localparam logic [4:0] CMD_LOAD    = 5'd4;
  localparam logic [4:0] CMD_STORE   = 5'd5;
  localparam logic [4:0] CMD_JMP     = 5'd6;
  localparam logic [4:0] CMD_RPUSH   = 5'd7;
  localparam logic [4:0] CMD_DROP    = 5'd8;
  localparam logic [4:0] CMD_RPOP    = 5'd9;
  localparam logic [4:0] CMD_RDROP   = 5'd10;
  localparam logic [4:0] CMD_ADD     = 5'd11;
  localparam logic [4:0] CMD_SUB     = 5'd12;
  localparam logic [4:0] CMD_MUL     = 5'd13;
  localparam logic [4:0] CMD_DIV     = 5'd14;
  localparam logic [4:0] CMD_MOD     = 5'd15;
  localparam logic [4:0] CMD_AND     = 5'd16;
  localparam logic [4:0] CMD_OR      = 5'd17;
  localparam logic [4:0] CMD_XOR     = 5'd18;
  localparam logic [4:0] CMD_LESS    = 5'd19;
  localparam logic [4:0] CMD_GREATER = 5'd20;
  localparam logic [4:0] CMD_SKIP_IF = 5'd21;
  localparam logic [4:0] CMD_SWAP    = 5'd22;
  localparam logic [4:0] CMD_START   = 5'd23;

  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_BYE     = 3'd1;
  localparam logic [2:0] ST_DUNDER  = 3'd2;
  localparam logic [2:0] ST_RUNDER  = 3'd3;
  localparam logic [2:0] ST_ZDIV    = 3'd4;
  localparam logic [2:0] ST_MEMF    = 3'd5;
  localparam logic [2:0] ST_OVF     = 3'd6;

  typedef struct packed {
    logic [4:0]  command;
    logic [31:0] literal;
  } fsmc_in_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [31:0] top_value;
    logic [5:0]  data_depth;
    logic [5:0]  return_depth;
    logic [2:0]  status;
  } fsmc_out_t;

  // Stack demands and operation kind of one opcode, worked out by the front end
  typedef struct packed {
    logic [1:0] need_d;
    logic       grow_d;
    logic       need_r;
    logic       grow_r;
    logic       mem_op;
    logic       div_op;
    logic       bin_op;
  } fsmc_cls_t;

  typedef struct packed {
    logic [4:0]  command;
    logic [31:0] literal;
    fsmc_cls_t   cls;
  } fsmc_item_t;

endpackage

/* hdl/fsmc_front.sv */
// Front end: instruction queue that classifies each opcode on entry.
`timescale 1ns / 1ps
module fsmc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  fsmc_pkg::fsmc_in_t  in_i,
  output logic                valid_o,
  input  logic                take_i,
  output fsmc_pkg::fsmc_item_t item_o
);
  import fsmc_pkg::*;

  fsmc_item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  fsmc_item_t cls_item;
  logic       do_push, do_pop;

  // Classify the incoming opcode; unknown codes run as none
  always_comb begin
    cls_item = '0;
    cls_item.literal = in_i.literal;
    cls_item.command = (in_i.command > CMD_START) ? CMD_NONE : in_i.command;
    unique case (cls_item.command)
      CMD_PUSH: cls_item.cls.grow_d = 1'b1;
      CMD_CALL, CMD_RPUSH: begin
        cls_item.cls.need_d = 2'd1;
        cls_item.cls.grow_r = 1'b1;
      end
      CMD_LOAD: begin
        cls_item.cls.need_d = 2'd1;
        cls_item.cls.mem_op = 1'b1;
      end
      CMD_STORE: begin
        cls_item.cls.need_d = 2'd2;
        cls_item.cls.mem_op = 1'b1;
      end
      CMD_JMP, CMD_DROP, CMD_SKIP_IF: cls_item.cls.need_d = 2'd1;
      CMD_RPOP: begin
        cls_item.cls.need_r = 1'b1;
        cls_item.cls.grow_d = 1'b1;
      end
      CMD_RDROP: cls_item.cls.need_r = 1'b1;
      CMD_DIV, CMD_MOD: begin
        cls_item.cls.need_d = 2'd2;
        cls_item.cls.div_op = 1'b1;
        cls_item.cls.bin_op = 1'b1;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_AND, CMD_OR, CMD_XOR, CMD_LESS, CMD_GREATER,
      CMD_SWAP: begin
        cls_item.cls.need_d = 2'd2;
        cls_item.cls.bin_op = 1'b1;
      end
      default: cls_item.cls = '0;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  // Advance queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

/* hdl/fsmc_back.sv */
// Back end: execution sequencer with stacks, word memory, divider and result queue.
`timescale 1ns / 1ps
module fsmc_back #(
  parameter int WORD_BITS    = fsmc_pkg::WORD_BITS_DEF,
  parameter int DATA_DEPTH   = fsmc_pkg::DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = fsmc_pkg::RETURN_DEPTH_DEF,
  parameter int MEM_WORDS    = fsmc_pkg::MEM_WORDS_DEF,
  parameter int PC_BITS      = fsmc_pkg::PC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 take_o,
  input  fsmc_pkg::fsmc_item_t item_i,
  input  logic                 true_we_i,
  input  logic [31:0]          true_value_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output fsmc_pkg::fsmc_out_t  res_o
);
  import fsmc_pkg::*;

  localparam int DC_BITS = $clog2(DATA_DEPTH + 1);
  localparam int DA_BITS = $clog2(DATA_DEPTH);
  localparam int RC_BITS = $clog2(RETURN_DEPTH + 1);
  localparam int RA_BITS = $clog2(RETURN_DEPTH);
  localparam int MA_BITS = $clog2(MEM_WORDS);
  localparam int DV_BITS = $clog2(WORD_BITS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RELOAD = 4'd1;
  localparam logic [3:0] S_RET    = 4'd2;
  localparam logic [3:0] S_RPOP   = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_STORE  = 4'd5;
  localparam logic [3:0] S_BIN    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [DC_BITS-1:0]   dcnt_q, dcnt_d;
  logic [RC_BITS-1:0]   rcnt_q, rcnt_d;
  logic [PC_BITS-1:0]   pc_q, pc_d;
  logic [2:0]           halt_q, halt_d;
  logic [WORD_BITS-1:0] top_q, top_d;
  logic [WORD_BITS-1:0] true_q;
  logic [4:0]           op_q, op_d;

  // Stores and their registered read data
  logic [WORD_BITS-1:0] ds_mem [DATA_DEPTH];
  logic [WORD_BITS-1:0] rs_mem [RETURN_DEPTH];
  logic [WORD_BITS-1:0] wm_mem [MEM_WORDS];
  logic [WORD_BITS-1:0] ds_rd_q, rs_rd_q, wm_rd_q;
  logic                 ds_re, rs_re, wm_re, ds_we, rs_we, wm_we;
  logic [DA_BITS-1:0]   ds_raddr, ds_waddr;
  logic [RA_BITS-1:0]   rs_raddr, rs_waddr;
  logic [MA_BITS-1:0]   wm_addr;
  logic [WORD_BITS-1:0] ds_wdata, rs_wdata, wm_wdata;

  // Divider state
  logic [WORD_BITS-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [DV_BITS-1:0]   dvc_q, dvc_d;
  logic [WORD_BITS:0]   dv_sh, dv_diff;

  // Result queue
  fsmc_out_t  oq_q [2];
  logic       oq_wr_q, oq_rd_q;
  logic [1:0] oq_cnt_q;
  logic       oq_push, oq_pop;
  fsmc_out_t  res_now;

  logic [2:0]           fault;
  logic                 top_nz;
  logic [DC_BITS-1:0]   dcnt_m1, dcnt_m2, dcnt_m3;
  logic [RC_BITS-1:0]   rcnt_m1;
  logic [WORD_BITS-1:0] lit_w, bin_res;
  logic [PC_BITS-1:0]   pc_p1;

  assign top_nz  = (top_q != '0);
  assign dcnt_m1 = dcnt_q - DC_BITS'(1);
  assign dcnt_m2 = dcnt_q - DC_BITS'(2);
  assign dcnt_m3 = dcnt_q - DC_BITS'(3);
  assign rcnt_m1 = rcnt_q - RC_BITS'(1);
  assign lit_w   = WORD_BITS'(item_i.literal);
  assign pc_p1   = pc_q + PC_BITS'(1);
  assign take_o  = (state_q == S_IDLE) && valid_i;

  // Check stack, range and divisor faults in order of precedence
  always_comb begin
    fault = ST_RUN;
    if (item_i.command == CMD_RET && rcnt_q == '0) begin
      fault = ST_BYE;
    end else if (dcnt_q < DC_BITS'(item_i.cls.need_d)) begin
      fault = ST_DUNDER;
    end else if (item_i.cls.need_r && rcnt_q == '0) begin
      fault = ST_RUNDER;
    end else if (item_i.cls.grow_r && rcnt_q >= RC_BITS'(RETURN_DEPTH)) begin
      fault = ST_OVF;
    end else if (item_i.cls.grow_d && dcnt_q >= DC_BITS'(DATA_DEPTH)) begin
      fault = ST_OVF;
    end else if (item_i.cls.mem_op && top_q >= WORD_BITS'(MEM_WORDS)) begin
      fault = ST_MEMF;
    end else if (item_i.cls.div_op && !top_nz) begin
      fault = ST_ZDIV;
    end
  end

  // Two-operand arithmetic, logic and compares; second is ds_rd_q, top is b
  always_comb begin
    case (op_q)
      CMD_ADD:     bin_res = ds_rd_q + top_q;
      CMD_SUB:     bin_res = ds_rd_q - top_q;
      CMD_MUL:     bin_res = ds_rd_q * top_q;
      CMD_AND:     bin_res = (ds_rd_q != '0 && top_nz) ? true_q : '0;
      CMD_OR:      bin_res = (ds_rd_q != '0 || top_nz) ? true_q : '0;
      CMD_XOR:     bin_res = ds_rd_q ^ top_q;
      CMD_LESS:    bin_res = ($signed(ds_rd_q) < $signed(top_q)) ? true_q : '0;
      CMD_GREATER: bin_res = ($signed(ds_rd_q) > $signed(top_q)) ? true_q : '0;
      default:     bin_res = ds_rd_q;
    endcase
  end

  assign dv_sh   = {rem_q, quo_q[WORD_BITS-1]};
  assign dv_diff = dv_sh - {1'b0, dvs_q};

  // Sequencer
  always_comb begin
    state_d  = state_q;
    dcnt_d   = dcnt_q;
    rcnt_d   = rcnt_q;
    pc_d     = pc_q;
    halt_d   = halt_q;
    top_d    = top_q;
    op_d     = op_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    dvc_d    = dvc_q;
    ds_re    = 1'b0;
    rs_re    = 1'b0;
    wm_re    = 1'b0;
    ds_we    = 1'b0;
    rs_we    = 1'b0;
    wm_we    = 1'b0;
    ds_raddr = dcnt_m2[DA_BITS-1:0];
    ds_waddr = dcnt_m1[DA_BITS-1:0];
    ds_wdata = top_q;
    rs_raddr = rcnt_m1[RA_BITS-1:0];
    rs_waddr = rcnt_q[RA_BITS-1:0];
    rs_wdata = top_q;
    wm_addr  = top_q[MA_BITS-1:0];
    wm_wdata = ds_rd_q;
    oq_push  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          state_d = S_EMIT;
          op_d    = item_i.command;
          if (halt_q != ST_RUN) begin
            state_d = S_EMIT;
          end else if (fault != ST_RUN) begin
            halt_d = fault;
            rcnt_d = '0;
            pc_d   = pc_p1;
          end else begin
            pc_d = pc_p1;
            case (item_i.command)
              CMD_START: pc_d = PC_BITS'(lit_w);
              CMD_PUSH: begin
                ds_we  = (dcnt_q != '0);
                top_d  = lit_w;
                dcnt_d = dcnt_q + DC_BITS'(1);
                pc_d   = pc_q + PC_BITS'(2);
              end
              CMD_RET: begin
                rs_re   = 1'b1;
                state_d = S_RET;
              end
              CMD_CALL, CMD_JMP, CMD_RPUSH, CMD_DROP, CMD_SKIP_IF: begin
                ds_re   = 1'b1;
                dcnt_d  = dcnt_m1;
                state_d = S_RELOAD;
                if (item_i.command == CMD_CALL || item_i.command == CMD_RPUSH) begin
                  rs_we    = 1'b1;
                  rs_wdata = (item_i.command == CMD_CALL) ? WORD_BITS'(pc_q) : top_q;
                  rcnt_d   = rcnt_q + RC_BITS'(1);
                end
                if (item_i.command == CMD_CALL || item_i.command == CMD_JMP) begin
                  pc_d = PC_BITS'(top_q);
                end
                if (item_i.command == CMD_SKIP_IF && top_nz) begin
                  pc_d = pc_q + PC_BITS'(SKIP_WORDS + 1);
                end
              end
              CMD_RPOP: begin
                rs_re   = 1'b1;
                state_d = S_RPOP;
              end
              CMD_RDROP: rcnt_d = rcnt_m1;
              CMD_LOAD: begin
                wm_re   = 1'b1;
                state_d = S_LOAD;
              end
              CMD_STORE: begin
                ds_re   = 1'b1;
                state_d = S_STORE;
              end
              default: begin
                if (item_i.cls.bin_op) begin
                  ds_re   = 1'b1;
                  state_d = S_BIN;
                end
              end
            endcase
          end
        end
      end
      S_RELOAD: begin
        top_d   = ds_rd_q;
        state_d = S_EMIT;
      end
      S_RET: begin
        pc_d    = PC_BITS'(rs_rd_q) + PC_BITS'(1);
        rcnt_d  = rcnt_m1;
        state_d = S_EMIT;
      end
      S_RPOP: begin
        ds_we   = (dcnt_q != '0);
        top_d   = rs_rd_q;
        dcnt_d  = dcnt_q + DC_BITS'(1);
        rcnt_d  = rcnt_m1;
        state_d = S_EMIT;
      end
      S_LOAD: begin
        top_d   = wm_rd_q;
        state_d = S_EMIT;
      end
      S_STORE: begin
        wm_we    = 1'b1;
        dcnt_d   = dcnt_m2;
        ds_re    = 1'b1;
        ds_raddr = dcnt_m3[DA_BITS-1:0];
        state_d  = S_RELOAD;
      end
      S_BIN: begin
        dcnt_d  = dcnt_m1;
        state_d = S_EMIT;
        if (op_q == CMD_SWAP) begin
          // Swap keeps the depth
          dcnt_d   = dcnt_q;
          ds_we    = 1'b1;
          ds_waddr = dcnt_m2[DA_BITS-1:0];
          top_d    = ds_rd_q;
        end else if (op_q == CMD_DIV || op_q == CMD_MOD) begin
          rem_d   = '0;
          quo_d   = ds_rd_q;
          dvs_d   = top_q;
          dvc_d   = DV_BITS'(WORD_BITS - 1);
          state_d = S_DIV;
        end else begin
          top_d = bin_res;
        end
      end
      S_DIV: begin
        if (!dv_diff[WORD_BITS]) begin
          rem_d = dv_diff[WORD_BITS-1:0];
        end else begin
          rem_d = dv_sh[WORD_BITS-1:0];
        end
        quo_d = {quo_q[WORD_BITS-2:0], !dv_diff[WORD_BITS]};
        dvc_d = dvc_q - DV_BITS'(1);
        if (dvc_q == '0) begin
          top_d   = (op_q == CMD_DIV) ? quo_d : rem_d;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (oq_cnt_q != 2'd2) begin
          oq_push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dcnt_q  <= '0;
      rcnt_q  <= '0;
      pc_q    <= '0;
      halt_q  <= ST_RUN;
      true_q  <= '1;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      rcnt_q  <= rcnt_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      if (true_we_i) begin
        true_q <= WORD_BITS'(true_value_i);
      end
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    op_q  <= op_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    dvc_q <= dvc_d;
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (ds_we) ds_mem[ds_waddr] <= ds_wdata;
    if (ds_re) ds_rd_q <= ds_mem[ds_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
    if (rs_re) rs_rd_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) wm_mem[wm_addr] <= wm_wdata;
    if (wm_re) wm_rd_q <= wm_mem[wm_addr];
  end

  // Build the result beat from the committed state
  always_comb begin
    res_now.next_pc      = 16'(pc_q);
    res_now.top_value    = (dcnt_q != '0) ? 32'(top_q) : 32'd0;
    res_now.data_depth   = 6'(dcnt_q);
    res_now.return_depth = 6'(rcnt_q);
    res_now.status       = halt_q;
  end

  assign empty_o = (oq_cnt_q == 2'd0);
  assign oq_pop  = pop_i && !empty_o;
  assign res_o   = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      oq_wr_q  <= oq_wr_q ^ oq_push;
      oq_rd_q  <= oq_rd_q ^ oq_pop;
      oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_q[oq_wr_q] <= res_now;
  end

endmodule

/* hdl/forth_stack_machine_core.sv */
// Top level of the Forth stack machine core: front queue feeding the execution back end.
// Each instruction runs from idle through its own states to emit: ret, rpop and load pass
// their read state; call, jmp, rpush, drop and skip_if pass reload; two-operand ops pass bin;
// store passes store then reload; div and mod pass bin, then divide once per quotient bit.
// Emit waits while the result queue is full; a new instruction is taken only from idle.
// Reset clears stack depths, program counter, status and queues; stacks and word
// memory hold no defined contents until written, and no clearing pass runs.
`timescale 1ns / 1ps
module forth_stack_machine_core #(
  parameter int WORD_BITS    = fsmc_pkg::WORD_BITS_DEF,
  parameter int DATA_DEPTH   = fsmc_pkg::DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = fsmc_pkg::RETURN_DEPTH_DEF,
  parameter int MEM_WORDS    = fsmc_pkg::MEM_WORDS_DEF,
  parameter int PC_BITS      = fsmc_pkg::PC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  fsmc_pkg::fsmc_in_t  in_i,
  output logic                empty,
  input  logic                pop,
  output fsmc_pkg::fsmc_out_t res_o,
  input  logic                true_we_i,
  input  logic [31:0]         true_value_i
);
  import fsmc_pkg::*;

  logic       fe_valid, fe_take;
  fsmc_item_t fe_item;

  fsmc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .in_i    (in_i),
    .valid_o (fe_valid),
    .take_i  (fe_take),
    .item_o  (fe_item)
  );

  fsmc_back #(
    .WORD_BITS    (WORD_BITS),
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH),
    .MEM_WORDS    (MEM_WORDS),
    .PC_BITS      (PC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (fe_valid),
    .take_o       (fe_take),
    .item_i       (fe_item),
    .true_we_i    (true_we_i),
    .true_value_i (true_value_i),
    .empty_o      (empty),
    .pop_i        (pop),
    .res_o        (res_o)
  );

endmodule

/* sim/forth_stack_machine_core_tb.sv */
// Self-checking testbench for the Forth stack machine core: directed table plus random programs.
`timescale 1ns / 1ps
module forth_stack_machine_core_tb;
  import fsmc_pkg::*;

  localparam int DDEPTH    = 32;
  localparam int RDEPTH    = 32;
  localparam int MEMW      = 1024;
  localparam int MAX_CYC   = 1500000;
  localparam int N_RANDOM  = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  fsmc_in_t    in_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  fsmc_out_t   res_o;
  logic        true_we_i = 1'b0;
  logic [31:0] true_value_i = '0;

  forth_stack_machine_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .res_o(res_o),
    .true_we_i(true_we_i), .true_value_i(true_value_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Machine state shadow
  logic [31:0] dstk [DDEPTH];
  logic [31:0] rstk [RDEPTH];
  logic [31:0] wmem [MEMW];
  bit          wmem_set [MEMW];
  int          dcnt, rcnt;
  logic [15:0] pc;
  logic [2:0]  halt;
  logic [31:0] truev;

  fsmc_out_t   expected_q [$];
  int          errors = 0;
  int          send_idle = 0, recv_idle = 0;
  int          cycles = 0;

  function automatic logic [31:0] truth(bit c);
    return c ? truev : 32'd0;
  endfunction

  // Execute one instruction on the shadow, return the machine view after it
  function automatic fsmc_out_t execute(fsmc_in_t it);
    fsmc_out_t   r;
    logic [31:0] a, b, npc;
    logic [2:0]  code;
    npc = 32'(pc) + 1;
    code = ST_RUN;
    if (halt == ST_RUN) begin
      case (it.command)
        CMD_PUSH: if (dcnt >= DDEPTH) code = ST_OVF;
          else begin dstk[dcnt] = it.literal; dcnt++; npc = 32'(pc) + 2; end
        CMD_RET: if (rcnt == 0) code = ST_BYE;
          else begin rcnt--; npc = rstk[rcnt] + 1; end
        CMD_CALL: if (dcnt < 1) code = ST_DUNDER;
          else if (rcnt >= RDEPTH) code = ST_OVF;
          else begin dcnt--; rstk[rcnt] = 32'(pc); rcnt++; npc = dstk[dcnt]; end
        CMD_LOAD: if (dcnt < 1) code = ST_DUNDER;
          else if (dstk[dcnt-1] >= MEMW) code = ST_MEMF;
          else dstk[dcnt-1] = wmem[dstk[dcnt-1]];
        CMD_STORE: if (dcnt < 2) code = ST_DUNDER;
          else if (dstk[dcnt-1] >= MEMW) code = ST_MEMF;
          else begin
            wmem[dstk[dcnt-1]] = dstk[dcnt-2];
            wmem_set[dstk[dcnt-1]] = 1'b1;
            dcnt -= 2;
          end
        CMD_JMP: if (dcnt < 1) code = ST_DUNDER;
          else begin dcnt--; npc = dstk[dcnt]; end
        CMD_RPUSH: if (dcnt < 1) code = ST_DUNDER;
          else if (rcnt >= RDEPTH) code = ST_OVF;
          else begin dcnt--; rstk[rcnt] = dstk[dcnt]; rcnt++; end
        CMD_DROP: if (dcnt < 1) code = ST_DUNDER; else dcnt--;
        CMD_RPOP: if (rcnt < 1) code = ST_RUNDER;
          else if (dcnt >= DDEPTH) code = ST_OVF;
          else begin rcnt--; dstk[dcnt] = rstk[rcnt]; dcnt++; end
        CMD_RDROP: if (rcnt < 1) code = ST_RUNDER; else rcnt--;
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_AND, CMD_OR, CMD_XOR,
        CMD_LESS, CMD_GREATER, CMD_SWAP: begin
          if (dcnt < 2) code = ST_DUNDER;
          else begin
            a = dstk[dcnt-2];
            b = dstk[dcnt-1];
            if (it.command == CMD_SWAP) begin
              dstk[dcnt-2] = b;
              dstk[dcnt-1] = a;
            end else if ((it.command == CMD_DIV || it.command == CMD_MOD) && b == 0) begin
              code = ST_ZDIV;
            end else begin
              case (it.command)
                CMD_ADD:  a = a + b;
                CMD_SUB:  a = a - b;
                CMD_MUL:  a = a * b;
                CMD_DIV:  a = a / b;
                CMD_MOD:  a = a % b;
                CMD_AND:  a = truth(a != 0 && b != 0);
                CMD_OR:   a = truth(a != 0 || b != 0);
                CMD_XOR:  a = a ^ b;
                CMD_LESS: a = truth($signed(a) < $signed(b));
                default:  a = truth($signed(a) > $signed(b));
              endcase
              dstk[dcnt-2] = a;
              dcnt--;
            end
          end
        end
        CMD_SKIP_IF: if (dcnt < 1) code = ST_DUNDER;
          else begin
            dcnt--;
            if (dstk[dcnt] != 0) npc = 32'(pc) + 1 + SKIP_WORDS;
          end
        CMD_START: npc = it.literal;
        default: ;
      endcase
      if (code != ST_RUN) begin
        halt = code;
        rcnt = 0;
        pc = pc + 1;
      end else begin
        pc = npc[15:0];
      end
    end
    r.next_pc = pc;
    r.top_value = dcnt ? dstk[dcnt-1] : 32'd0;
    r.data_depth = 6'(dcnt);
    r.return_depth = 6'(rcnt);
    r.status = halt;
    return r;
  endfunction

  // Compare each popped beat with the oldest expectation
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        errors++;
      end else begin
        fsmc_out_t e;
        e = expected_q.pop_front();
        if (res_o.next_pc !== e.next_pc)
          $display("%0t: next_pc exp %h got %h", $time, e.next_pc, res_o.next_pc);
        if (res_o.top_value !== e.top_value)
          $display("%0t: top_value exp %h got %h", $time, e.top_value, res_o.top_value);
        if (res_o.data_depth !== e.data_depth)
          $display("%0t: data_depth exp %0d got %0d", $time, e.data_depth, res_o.data_depth);
        if (res_o.return_depth !== e.return_depth)
          $display("%0t: return_depth exp %0d got %0d", $time, e.return_depth,
                   res_o.return_depth);
        if (res_o.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, res_o.status);
        if (res_o !== e) errors++;
      end
    end
  end

  // Receiver side: stall at random
  always @(negedge clk_i) pop <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    if (cycles > MAX_CYC) begin
      $display("forth_stack_machine_core_tb NOT OK");
      $finish;
    end
  end

  // Send one beat and leave push high; the next send or a drain drops it
  task automatic send(logic [4:0] cmd, logic [31:0] lit);
    fsmc_in_t it;
    it.command = cmd;
    it.literal = lit;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_q.push_back(execute(it));
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_true(logic [31:0] v);
    drain();
    true_we_i <= 1'b1;
    true_value_i <= v;
    truev = v;
    @(negedge clk_i);
    true_we_i <= 1'b0;
  endtask

  // Clear the shadow only; restarting a halted machine needs a reset, which is not allowed,
  // so the random phases avoid halts and only the final overflow check halts the machine.
  task automatic shadow_reset();
    dcnt = 0; rcnt = 0; pc = '0; halt = ST_RUN; truev = 32'hFFFF_FFFF;
    foreach (wmem_set[i]) wmem_set[i] = 1'b0;
  endtask

  typedef struct {
    logic [4:0]  cmd;
    logic [31:0] lit;
    bit          has_exp;
    fsmc_out_t   exp_res;
  } row_t;

  // Pick a command that keeps the machine running
  task automatic random_safe();
    logic [4:0]  c;
    logic [31:0] l;
    int          k;
    l = $urandom();
    k = $urandom_range(19);
    if (dcnt < 2 || k < 4) begin
      c = (dcnt < DDEPTH - 1) ? CMD_PUSH : CMD_DROP;
      case ($urandom_range(3))
        0: l = $urandom_range(MEMW - 1);
        1: l = $urandom_range(3);
        2: l = {$urandom_range(1), 31'($urandom())};
        default: ;
      endcase
      if (dcnt >= 1 && c == CMD_PUSH && $urandom_range(7) == 0) c = CMD_START;
    end else begin
      case (k)
        4:  c = CMD_ADD;   5: c = CMD_SUB;   6: c = CMD_MUL;
        7:  c = (dstk[dcnt-1] != 0) ? CMD_DIV : CMD_XOR;
        8:  c = (dstk[dcnt-1] != 0) ? CMD_MOD : CMD_SWAP;
        9:  c = CMD_AND;  10: c = CMD_OR;    11: c = CMD_LESS;
        12: c = CMD_GREATER; 13: c = CMD_SWAP; 14: c = CMD_SKIP_IF;
        15: c = (rcnt < RDEPTH) ? CMD_RPUSH : CMD_DROP;
        16: c = (rcnt > 0 && dcnt < DDEPTH) ? CMD_RPOP : CMD_DROP;
        17: c = (rcnt > 0) ? ($urandom_range(1) ? CMD_RDROP : CMD_RET) : CMD_JMP;
        18: c = (dstk[dcnt-1] < MEMW && wmem_set[dstk[dcnt-1]]) ? CMD_LOAD
              : (dstk[dcnt-1] < MEMW) ? CMD_STORE : CMD_DROP;
        default: c = (rcnt < RDEPTH) ? CMD_CALL : CMD_NONE;
      endcase
      if ($urandom_range(30) == 0) c = 5'(24 + $urandom_range(7));
    end
    send(c, l);
  endtask

  row_t        dir [$];
  row_t        rw;
  fsmc_out_t   got;

  initial begin
    shadow_reset();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: extremes, memory, divide and return-stack opcodes, compare signs, skip at the end
    dir = '{
      '{CMD_NONE,  32'd0,          1, '{16'd1, 32'd0, 6'd0, 6'd0, ST_RUN}},
      '{CMD_PUSH,  32'hFFFF_FFFF,  1, '{16'd3, 32'hFFFF_FFFF, 6'd1, 6'd0, ST_RUN}},
      '{CMD_PUSH,  32'h8000_0000,  0, '{default: '0}},
      '{CMD_LESS,  32'd0,          0, '{default: '0}},
      '{CMD_PUSH,  32'h7FFF_FFFF,  0, '{default: '0}},
      '{CMD_PUSH,  32'h8000_0000,  0, '{default: '0}},
      '{CMD_GREATER, 32'd0,        0, '{default: '0}},
      '{CMD_PUSH,  32'd3,          0, '{default: '0}},
      '{CMD_PUSH,  32'd1023,       0, '{default: '0}},
      '{CMD_STORE, 32'd0,          0, '{default: '0}},
      '{CMD_PUSH,  32'd1023,       0, '{default: '0}},
      '{CMD_LOAD,  32'd0,          0, '{default: '0}},
      '{CMD_PUSH,  32'd7,          0, '{default: '0}},
      '{CMD_DIV,   32'd0,          0, '{default: '0}},
      '{CMD_PUSH,  32'd5,          0, '{default: '0}},
      '{CMD_MOD,   32'd0,          0, '{default: '0}},
      '{CMD_RPUSH, 32'd0,          0, '{default: '0}},
      '{CMD_RPOP,  32'd0,          0, '{default: '0}},
      '{CMD_RPUSH, 32'd0,          0, '{default: '0}},
      '{CMD_RDROP, 32'd0,          0, '{default: '0}},
      '{CMD_START, 32'h0001_FFFF,  1, '{16'hFFFF, 32'hFFFF_FFFF, 6'd2, 6'd0, ST_RUN}},
      '{CMD_PUSH,  32'd0,          0, '{default: '0}},
      '{CMD_SKIP_IF, 32'd0,        0, '{default: '0}}
    };
    foreach (dir[i]) begin
      rw = dir[i];
      send(rw.cmd, rw.lit);
      if (rw.has_exp && expected_q[$] !== rw.exp_res) begin
        $display("%0t: table row %0d exp %h model %h", $time, i, rw.exp_res, expected_q[$]);
        errors++;
      end
    end

    // Random phases with varied true words, idling profiles swapped then off
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 10 : (ph == 1) ? 79 : 0;
      recv_idle = (ph == 0) ? 79 : (ph == 1) ? 10 : 0;
      write_true((ph == 0) ? 32'd0 : (ph == 1) ? 32'd1 : $urandom());
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        random_safe();
        if (n == 100) drain();
      end
      drain();
    end
    write_true(32'hFFFF_FFFF);

    // Fill to overflow, then prove the halt is sticky
    while (dcnt < DDEPTH && halt == ST_RUN) send(CMD_PUSH, $urandom());
    send(CMD_PUSH, 32'd1);
    send(CMD_START, 32'd0);
    send(CMD_ADD, 32'd0);

    drain();
    if (errors == 0) $display("forth_stack_machine_core_tb OK");
    else $display("forth_stack_machine_core_tb NOT OK");
    $finish;
  end
endmodule
